// ===== rtl/dfa_pkg.sv =====
// ----------------------------------------------------------------------------
// dfa_pkg
// shared types and constants for the depth frame averager
// ----------------------------------------------------------------------------
package dfa_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int MAX_FRAMES   = 64;
    localparam int PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int PIX_W        = $clog2(PIXELS);
    localparam int CNT_W        = $clog2(MAX_FRAMES + 1);
    localparam int FRM_W        = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W        = 16 + CNT_W;

    typedef logic signed [15:0]      coord_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [PIX_W-1:0]        pix_t;
    typedef logic [18:0]             stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/dfa_div_lane.sv =====
// ----------------------------------------------------------------------------
// dfa_div_lane
// one lane: signed sum over unsigned count, truncating, restoring divider
// ----------------------------------------------------------------------------
module dfa_div_lane (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dfa_pkg::sum_t sum,
    input  dfa_pkg::cnt_t cnt,
    output logic          done,
    output dfa_pkg::sum_t quot
);
    import dfa_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic [SUM_W:0]    trial;
    logic [SUM_W-1:0]  shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
        trial     = {1'b0, shifted} - {{(SUM_W+1-CNT_W){1'b0}}, den_reg};
        if (start)
        begin
            neg_next  = sum[SUM_W-1];
            quo_next  = sum[SUM_W-1] ? SUM_W'(-sum) : sum;
            rem_next  = '0;
            den_next  = cnt;
            step_next = STEP_W'(SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[SUM_W])
                rem_next = trial[SUM_W-1:0];
            else
                rem_next = shifted;
            quo_next  = {quo_reg[SUM_W-2:0], ~trial[SUM_W]};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done = busy_reg && (step_reg == STEP_W'(1));
    assign quot = neg_reg ? sum_t'(-quo_reg) : sum_t'(quo_reg);

endmodule

// ===== rtl/dfa_merge.sv =====
// ----------------------------------------------------------------------------
// dfa_merge
// combines lane quotients: x and y negation, saturation, the pixel valid flag used by the statistics
// ----------------------------------------------------------------------------
module dfa_merge (
    input  dfa_pkg::sum_t  qx,
    input  dfa_pkg::sum_t  qy,
    input  dfa_pkg::sum_t  qz,
    input  dfa_pkg::cnt_t  cnt,
    output dfa_pkg::coord_t ax,
    output dfa_pkg::coord_t ay,
    output dfa_pkg::coord_t az,
    output logic           pvalid
);
    import dfa_pkg::*;

    function automatic coord_t sat16(input logic signed [SUM_W:0] v);
        coord_t r;
        if (v > (SUM_W+1)'(32767))
            r = 16'sh7fff;
        else if (v < -(SUM_W+1)'(32768))
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    assign pvalid = (cnt != '0);
    assign ax = pvalid ? sat16(-{qx[SUM_W-1], qx}) : '0;
    assign ay = pvalid ? sat16(-{qy[SUM_W-1], qy}) : '0;
    assign az = pvalid ? sat16({qz[SUM_W-1], qz}) : '0;

endmodule

// ===== rtl/depth_frame_averager.sv =====
// ----------------------------------------------------------------------------
// depth_frame_averager
// per-pixel temporal averaging of depth frames with dead-pixel masking
// ----------------------------------------------------------------------------
// usage: points enter in raster order on coord_valid/coord_stall as x, y, z.
// an all-zero point is dead and is skipped from sums and counts.
// frames_to_average is written through cfg_valid/cfg_ready while idle.
// during frames before the last, a point is read, added and written back
// and yields no transaction. in the last frame each point also runs three
// parallel divider lanes (x, y, z) over SUM_W (23) quotient bits; the result
// is then registered in the output stage.
// the per-point sequence is set by the pixel memory port (one access a
// cycle) and by the bit-serial dividers.
// the output register holds while out_stall is high; the next point is
// only taken once the result has been delivered.
// reset: position counters and totals clear, frames_to_average becomes 8;
// the pixel memory is not cleared, frame zero overwrites every entry.
// ----------------------------------------------------------------------------
module depth_frame_averager (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [6:0]       frames_to_average,
    input  logic             coord_valid,
    output logic             coord_stall,
    input  dfa_pkg::coord_t  coord_x,
    input  dfa_pkg::coord_t  coord_y,
    input  dfa_pkg::coord_t  coord_z,
    output logic             out_valid,
    input  logic             out_stall,
    output dfa_pkg::coord_t  avg_x,
    output dfa_pkg::coord_t  avg_y,
    output dfa_pkg::coord_t  avg_z,
    output logic             point_valid,
    output logic             frame_done,
    output dfa_pkg::stat_t   dead_pixels,
    output dfa_pkg::stat_t   alive_pixels,
    output dfa_pkg::stat_t   restored_pixels
);
    import dfa_pkg::*;

    localparam int ENT_W = 3 * SUM_W + CNT_W;

    logic [ENT_W-1:0] mem [PIXELS];
    logic [ENT_W-1:0] rd_reg;

    state_t state_reg, state_next;
    logic [6:0]       frames_reg;
    pix_t             pix_reg;
    logic [FRM_W-1:0] frm_reg;
    stat_t            dead_reg, alive_reg;
    coord_t           in_x_reg, in_y_reg, in_z_reg;
    cnt_t             cnt_reg;
    logic             ovalid_reg;
    coord_t           ox_reg, oy_reg, oz_reg;
    logic             opv_reg, odone_reg;
    stat_t            od_reg, oa_reg, or_reg;

    logic [FRM_W-1:0] eff_frames;
    logic             in_acc, pt_live, last_frame, last_pixel;
    sum_t             nx, ny, nz;
    cnt_t             ncnt;
    logic             div_start;
    logic             done_x, done_y, done_z;
    sum_t             qx, qy, qz;
    coord_t           mx, my, mz;
    logic             mpv;
    stat_t            dead_inc, alive_inc;

    assign eff_frames = (frames_reg == '0) ? FRM_W'(1) :
                        (frames_reg > 7'(MAX_FRAMES)) ? FRM_W'(MAX_FRAMES) :
                        FRM_W'(frames_reg);
    assign cfg_ready   = (state_reg == ST_IDLE) && !ovalid_reg;
    assign coord_stall = !((state_reg == ST_IDLE) && !ovalid_reg);
    assign in_acc      = coord_valid && !coord_stall;
    assign pt_live     = (in_x_reg != '0) || (in_y_reg != '0) || (in_z_reg != '0);
    assign last_frame  = ({1'b0, frm_reg} + 1'b1) >= {1'b0, eff_frames};
    assign last_pixel  = ({1'b0, pix_reg} + 1'b1) >= (PIX_W+1)'(PIXELS);

    // add stage, frame zero overwrites the entry
    always_comb
    begin
        if (frm_reg == '0)
        begin
            nx   = pt_live ? sum_t'(in_x_reg) : '0;
            ny   = pt_live ? sum_t'(in_y_reg) : '0;
            nz   = pt_live ? sum_t'(in_z_reg) : '0;
            ncnt = pt_live ? cnt_t'(1) : '0;
        end
        else
        begin
            nx   = rd_reg[3*SUM_W+CNT_W-1 -: SUM_W] + (pt_live ? sum_t'(in_x_reg) : '0);
            ny   = rd_reg[2*SUM_W+CNT_W-1 -: SUM_W] + (pt_live ? sum_t'(in_y_reg) : '0);
            nz   = rd_reg[SUM_W+CNT_W-1 -: SUM_W] + (pt_live ? sum_t'(in_z_reg) : '0);
            ncnt = rd_reg[CNT_W-1:0] + cnt_t'(pt_live);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_READ;
            ST_READ: state_next = ST_ACC;
            ST_ACC:  state_next = last_frame ? ST_DIV : ST_IDLE;
            ST_DIV:  if (done_x && done_y && done_z) state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // lanes load the fresh sums straight from the add stage
    assign div_start = (state_reg == ST_ACC) && last_frame;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
            rd_reg <= mem[(in_acc && pix_reg < PIX_W'(PIXELS)) ? pix_reg : '0];
        if (state_reg == ST_READ)
            rd_reg <= mem[pix_reg];
        if (state_reg == ST_ACC)
            mem[pix_reg] <= {nx, ny, nz, ncnt};
        if (in_acc)
        begin
            in_x_reg <= coord_x;
            in_y_reg <= coord_y;
            in_z_reg <= coord_z;
        end
        if (state_reg == ST_ACC)
            cnt_reg <= ncnt;
    end

    dfa_div_lane u_lane_x (.clk, .rst_n, .start(div_start), .sum(nx), .cnt(ncnt),
                           .done(done_x), .quot(qx));
    dfa_div_lane u_lane_y (.clk, .rst_n, .start(div_start), .sum(ny), .cnt(ncnt),
                           .done(done_y), .quot(qy));
    dfa_div_lane u_lane_z (.clk, .rst_n, .start(div_start), .sum(nz), .cnt(ncnt),
                           .done(done_z), .quot(qz));

    dfa_merge u_merge (.qx, .qy, .qz, .cnt(cnt_reg), .ax(mx), .ay(my), .az(mz), .pvalid(mpv));

    assign dead_inc  = dead_reg + stat_t'(!mpv);
    assign alive_inc = alive_reg + stat_t'({1'b0, cnt_reg} == {1'b0, eff_frames});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            frames_reg <= 7'd8;
            pix_reg    <= '0;
            frm_reg    <= '0;
            dead_reg   <= '0;
            alive_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                frames_reg <= frames_to_average;
            if (ovalid_reg && !out_stall)
                ovalid_reg <= 1'b0;
            if (state_reg == ST_IDLE && in_acc && pix_reg >= PIX_W'(PIXELS))
                pix_reg <= '0;
            if (state_reg == ST_ACC && !last_frame)
            begin
                if (last_pixel)
                begin
                    pix_reg <= '0;
                    frm_reg <= frm_reg + 1'b1;
                end
                else
                    pix_reg <= pix_reg + 1'b1;
            end
            if (state_reg == ST_OUT)
            begin
                ovalid_reg <= 1'b1;
                if (last_pixel)
                begin
                    pix_reg   <= '0;
                    frm_reg   <= '0;
                    dead_reg  <= '0;
                    alive_reg <= '0;
                end
                else
                begin
                    pix_reg   <= pix_reg + 1'b1;
                    dead_reg  <= dead_inc;
                    alive_reg <= alive_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT)
        begin
            ox_reg    <= mx;
            oy_reg    <= my;
            oz_reg    <= mz;
            opv_reg   <= mpv;
            odone_reg <= last_pixel;
            od_reg    <= last_pixel ? dead_inc : '0;
            oa_reg    <= last_pixel ? alive_inc : '0;
            or_reg    <= last_pixel ? stat_t'(PIXELS) - dead_inc - alive_inc : '0;
        end
    end

    assign out_valid       = ovalid_reg;
    assign avg_x           = ox_reg;
    assign avg_y           = oy_reg;
    assign avg_z           = oz_reg;
    assign point_valid     = opv_reg;
    assign frame_done      = odone_reg;
    assign dead_pixels     = od_reg;
    assign alive_pixels    = oa_reg;
    assign restored_pixels = or_reg;

endmodule

// ===== rtl/dfa_checker.sv =====
// ----------------------------------------------------------------------------
// dfa_checker
// port-level checks on the depth frame averager
// ----------------------------------------------------------------------------
module dfa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           coord_valid,
    input logic           coord_stall,
    input logic           out_valid,
    input logic           out_stall,
    input logic           point_valid,
    input logic           frame_done,
    input dfa_pkg::coord_t avg_x,
    input dfa_pkg::stat_t dead_pixels
);
    import dfa_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(avg_x))
        else $error("output changed while stalled");

    // no point taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> coord_stall)
        else $error("input taken with result pending");

    // an accepted point keeps the block busy on the next cycle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        coord_valid && !coord_stall |=> coord_stall)
        else $error("input taken on consecutive cycles");

    // dead pixel gives zero average
    a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> avg_x == '0)
        else $error("dead pixel with nonzero average");

    // statistics only on the last pixel
    a_stats: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> dead_pixels == '0)
        else $error("statistics outside last pixel");

endmodule

bind depth_frame_averager dfa_checker u_dfa_checker (
    .clk, .rst_n, .coord_valid, .coord_stall, .out_valid, .out_stall,
    .point_valid, .frame_done, .avg_x, .dead_pixels
);
